FILE: rtl/iprtl_pkg.sv
// ----------------------------------------------------------------------------
// iprtl_pkg
// Shared constants, field layout and controller/datapath interface types for
// the IPv4 range table lookup core.
// ----------------------------------------------------------------------------
package iprtl_pkg;

  // Table sizes
  localparam int PREFIX_ENTRIES = 65536;
  localparam int RECORD_DEPTH   = 262144;
  localparam int PFX_IDX_W      = $clog2(PREFIX_ENTRIES);
  localparam int REC_IDX_W      = $clog2(RECORD_DEPTH);
  // Scan index carries one extra bit so it can reach the record limit itself
  localparam int SCAN_W         = REC_IDX_W + 1;

  // Field widths
  localparam int OP_W     = 2;
  localparam int ENTRY_W  = 18;
  localparam int FIRST_W  = 18;
  localparam int IP_W     = 32;
  localparam int OFFSET_W = 24;
  localparam int LENGTH_W = 16;
  localparam int LIMIT_W  = 19;

  // Input tdata layout, lowest bit first
  localparam int ENTRY_LSB   = 0;
  localparam int FIRST_LSB   = ENTRY_LSB + ENTRY_W;
  localparam int END_LSB     = FIRST_LSB + FIRST_W;
  localparam int OFFSET_LSB  = END_LSB + IP_W;
  localparam int LENGTH_LSB  = OFFSET_LSB + OFFSET_W;
  localparam int QUERY_LSB   = LENGTH_LSB + LENGTH_W;
  localparam int IN_FIELDS_W = QUERY_LSB + IP_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  // Output tdata width
  localparam int OUT_DATA_W  = OFFSET_W + LENGTH_W;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_WRITE_PREFIX = 2'd0,
    OP_WRITE_RECORD = 2'd1,
    OP_LOOKUP       = 2'd2,
    OP_NONE         = 2'd3
  } op_t;

  // One record as stored in the record memory
  typedef struct packed {
    logic [IP_W-1:0]     end_ip;
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
  } rec_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic wr_prefix;
    logic wr_record;
    logic load;
    logic pfx_rd;
    logic idx_load;
    logic rec_rd;
    logic set_found;
    logic idx_inc;
    logic publish;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic below_limit;
    logic covers;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/iprtl_ctrl.sv
// ----------------------------------------------------------------------------
// iprtl_ctrl
// Sequencer for table writes and lookups: accepts one beat at a time, walks
// the prefix read, the record scan and the hand-off to the output register.
// ----------------------------------------------------------------------------
module iprtl_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [iprtl_pkg::OP_W-1:0]    in_op,
  output logic                          in_ready,
  input  iprtl_pkg::sts_t               sts,
  output iprtl_pkg::cmd_t               cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PFX_RD,
    ST_IDX_LOAD,
    ST_SCAN,
    ST_CHECK,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Decode state and status into next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (iprtl_pkg::op_t'(in_op))
            iprtl_pkg::OP_WRITE_PREFIX: cmd.wr_prefix = 1'b1;
            iprtl_pkg::OP_WRITE_RECORD: cmd.wr_record = 1'b1;
            iprtl_pkg::OP_LOOKUP: begin
              cmd.load   = 1'b1;
              state_next = ST_PFX_RD;
            end
            default: ;
          endcase
        end
      end
      ST_PFX_RD: begin
        cmd.pfx_rd = 1'b1;
        state_next = ST_IDX_LOAD;
      end
      ST_IDX_LOAD: begin
        cmd.idx_load = 1'b1;
        state_next   = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.below_limit) begin
          cmd.rec_rd = 1'b1;
          state_next = ST_CHECK;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_CHECK: begin
        if (sts.covers) begin
          cmd.set_found = 1'b1;
          state_next    = ST_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_SCAN;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/iprtl_datapath.sv
// ----------------------------------------------------------------------------
// iprtl_datapath
// Prefix and record memories, record limit register, scan index, match
// result and the output register.
// ----------------------------------------------------------------------------
module iprtl_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [iprtl_pkg::IN_DATA_W-1:0]      in_data,
  input  logic                                 cfg_write,
  input  logic [iprtl_pkg::LIMIT_W-1:0]        cfg_data,
  input  iprtl_pkg::cmd_t                      cmd,
  output iprtl_pkg::sts_t                      sts,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_hit,
  output logic [iprtl_pkg::OFFSET_W-1:0]       out_offset,
  output logic [iprtl_pkg::LENGTH_W-1:0]       out_length
);

  // Input field slices
  logic [iprtl_pkg::ENTRY_W-1:0]  entry_index;
  logic [iprtl_pkg::FIRST_W-1:0]  first_record;
  iprtl_pkg::rec_t                wr_rec;
  logic [iprtl_pkg::IP_W-1:0]     query_ip;

  assign entry_index   = in_data[iprtl_pkg::ENTRY_LSB +: iprtl_pkg::ENTRY_W];
  assign first_record  = in_data[iprtl_pkg::FIRST_LSB +: iprtl_pkg::FIRST_W];
  assign wr_rec.end_ip = in_data[iprtl_pkg::END_LSB +: iprtl_pkg::IP_W];
  assign wr_rec.offset = in_data[iprtl_pkg::OFFSET_LSB +: iprtl_pkg::OFFSET_W];
  assign wr_rec.length = in_data[iprtl_pkg::LENGTH_LSB +: iprtl_pkg::LENGTH_W];
  assign query_ip      = in_data[iprtl_pkg::QUERY_LSB +: iprtl_pkg::IP_W];

  // Memories
  logic [iprtl_pkg::FIRST_W-1:0] pfx_mem [iprtl_pkg::PREFIX_ENTRIES];
  iprtl_pkg::rec_t               rec_mem [iprtl_pkg::RECORD_DEPTH];

  // Registers
  logic [iprtl_pkg::LIMIT_W-1:0]  limit;
  logic [iprtl_pkg::IP_W-1:0]     query;
  logic [iprtl_pkg::FIRST_W-1:0]  pfx_rd_data;
  iprtl_pkg::rec_t                rec_rd_data;
  logic [iprtl_pkg::SCAN_W-1:0]   scan_idx;
  logic                           found;

  logic pfx_we;
  logic rec_we;

  assign pfx_we = cmd.wr_prefix && (32'(entry_index) < iprtl_pkg::PREFIX_ENTRIES);
  assign rec_we = cmd.wr_record && (32'(entry_index) < iprtl_pkg::RECORD_DEPTH);

  // Write prefix memory
  always_ff @(posedge clk) begin
    if (pfx_we) begin
      pfx_mem[entry_index[iprtl_pkg::PFX_IDX_W-1:0]] <= first_record;
    end
  end

  // Read prefix entry for the query's top bits
  always_ff @(posedge clk) begin
    if (cmd.pfx_rd) begin
      pfx_rd_data <= pfx_mem[query[iprtl_pkg::IP_W-1 -: iprtl_pkg::PFX_IDX_W]];
    end
  end

  // Write record memory
  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[iprtl_pkg::REC_IDX_W'(entry_index)] <= wr_rec;
    end
  end

  // Read record at the scan index
  always_ff @(posedge clk) begin
    if (cmd.rec_rd) begin
      rec_rd_data <= rec_mem[scan_idx[iprtl_pkg::REC_IDX_W-1:0]];
    end
  end

  // Hold record limit, clamped to the store depth
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= '0;
    end else if (cfg_write) begin
      if (32'(cfg_data) > iprtl_pkg::RECORD_DEPTH) begin
        limit <= iprtl_pkg::LIMIT_W'(iprtl_pkg::RECORD_DEPTH);
      end else begin
        limit <= cfg_data;
      end
    end
  end

  // Capture query, advance scan index, track match
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.load) begin
      found <= 1'b0;
    end else if (cmd.set_found) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      query <= query_ip;
    end
    if (cmd.idx_load) begin
      scan_idx <= iprtl_pkg::SCAN_W'(pfx_rd_data);
    end else if (cmd.idx_inc) begin
      scan_idx <= scan_idx + iprtl_pkg::SCAN_W'(1);
    end
  end

  // Output register: load on publish, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_hit    <= found;
      out_offset <= found ? rec_rd_data.offset : '0;
      out_length <= found ? rec_rd_data.length : '0;
    end
  end

  // Status
  assign sts.below_limit = (32'(scan_idx) < 32'(limit));
  assign sts.covers      = (rec_rd_data.end_ip >= query);
  assign sts.out_free    = !out_valid || out_ready;

endmodule

FILE: rtl/ipv4_range_table_lookup_core.sv
// A table write is taken while the core is idle and leaves it ready; a
// lookup walks the prefix read, the index load and, per record, a limit
// check and a cover test, then loads the result register once it is free.
// One item at a time: a lookup holds off the input until that load.
// Reset: rst clears the record limit, the sequencer and the output valid;
// table contents stay undefined until written.
// ----------------------------------------------------------------------------
// ipv4_range_table_lookup_core
// IPv4 range lookup over a prefix index and a sorted record table, with
// stream-style input and output and a record limit write port.
// ----------------------------------------------------------------------------
module ipv4_range_table_lookup_core (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // entry_index[17:0], first_record[35:18], range_end_ip[67:36],
  // record_data_offset[91:68], record_data_length[107:92], query_ip[139:108]
  input  logic [iprtl_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // operation[1:0]
  input  logic [iprtl_pkg::OP_W-1:0]         s_axis_tuser,
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // data_offset[23:0], data_length[39:24]
  output logic [iprtl_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // hit[0]
  output logic                               m_axis_tuser,
  // Record limit write
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [iprtl_pkg::LIMIT_W-1:0]      cfg_data
);

  iprtl_pkg::cmd_t                 cmd;
  iprtl_pkg::sts_t                 sts;
  logic [iprtl_pkg::OFFSET_W-1:0]  out_offset;
  logic [iprtl_pkg::LENGTH_W-1:0]  out_length;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = {out_length, out_offset};

  iprtl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  iprtl_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_data    (s_axis_tdata),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_hit    (m_axis_tuser),
    .out_offset (out_offset),
    .out_length (out_length)
  );

endmodule
